### src/ort_pkg.sv
// ----------------------------------------------------------------------------
// ort_pkg
// Types, codes and defaults shared by the outstanding request tracker.
// ----------------------------------------------------------------------------
package ort_pkg;

    localparam int DEF_MAX_ENTRIES = 8;
    localparam logic [31:0] TIMEOUT_RESET = 32'd5000;

    // operation codes
    localparam logic [1:0] OP_START   = 2'd0;
    localparam logic [1:0] OP_ADD     = 2'd1;
    localparam logic [1:0] OP_RESOLVE = 2'd2;
    localparam logic [1:0] OP_EXPIRE  = 2'd3;

    // resolution codes
    localparam logic [1:0] RES_UNKNOWN   = 2'd0;
    localparam logic [1:0] RES_LATE      = 2'd1;
    localparam logic [1:0] RES_PENDING   = 2'd2;
    localparam logic [1:0] RES_COMPLETED = 2'd3;

    // batch status codes
    localparam logic [1:0] BST_PENDING  = 2'd0;
    localparam logic [1:0] BST_ALL_OK   = 2'd1;
    localparam logic [1:0] BST_PARTIAL  = 2'd2;
    localparam logic [1:0] BST_ALL_FAIL = 2'd3;

    typedef struct packed {
        logic [1:0]  operation;
        logic [31:0] request_id;
        logic        success;
        logic [31:0] time_now;
    } t_in_item;

    typedef struct packed {
        logic       add_accepted;
        logic [1:0] resolution;
        logic       expired;
        logic [3:0] total_count;
        logic [3:0] pending_count;
        logic [3:0] success_count;
        logic [3:0] failure_count;
        logic [1:0] batch_status;
    } t_out_item;

    // result of comparing one stored entry against the searched identifier
    typedef struct packed {
        logic match;
        logic resolved;
    } t_lookup;

endpackage

### src/ort_id_store.sv
// ----------------------------------------------------------------------------
// ort_id_store
// Identifier table with resolved flags: one write port, one registered read
// port, and the identifier comparator used for every step of a table walk.
// ----------------------------------------------------------------------------
module ort_id_store #(
    parameter int MAX_ENTRIES = 8,
    localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1
) (
    input  logic            i_clk,
    input  logic            i_wr_en,
    input  logic [IW-1:0]   i_wr_addr,
    input  logic [31:0]     i_wr_id,
    input  logic            i_wr_resolved,
    input  logic [IW-1:0]   i_rd_addr,
    input  logic [31:0]     i_key,
    output ort_pkg::t_lookup o_lookup
);
    import ort_pkg::*;

    // entry word: resolved flag on top of the identifier
    logic [32:0] r_mem [MAX_ENTRIES];
    logic [32:0] r_rd_word;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= {i_wr_resolved, i_wr_id};
        end
        r_rd_word <= r_mem[i_rd_addr];
    end

    assign o_lookup.match    = (r_rd_word[31:0] == i_key);
    assign o_lookup.resolved = r_rd_word[32];

endmodule

### src/outstanding_request_tracker_core.sv
// ----------------------------------------------------------------------------
// outstanding_request_tracker_core
// Tracks a batch of outstanding request identifiers, counts successes and
// failures, and expires pending requests after a timeout.
//
//   channel | direction | signals                            | payload
//   --------+-----------+------------------------------------+-------------
//   in      | in        | i_in_valid / o_in_ready            | t_in_item
//   out     | out       | o_out_valid / i_out_ready          | t_out_item
//   cfg     | in        | i_cfg_valid / o_cfg_ready          | timeout_ticks
//
// Start goes through FINISH; an expiry check goes through SUB, where the elapsed
// time is registered, then FINISH. Add and resolve walk the table through one
// comparator at one entry per cycle after a registered read.
// One item at a time; in is ready only when the sequencer is idle. A result
// held on out does not block the next transfer on in.
// Synchronous reset empties the batch and loads the timeout default; the
// table itself is not cleared, entries beyond the fill count are never used.
// ----------------------------------------------------------------------------
module outstanding_request_tracker_core #(
    parameter int MAX_ENTRIES = ort_pkg::DEF_MAX_ENTRIES
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  ort_pkg::t_in_item i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output ort_pkg::t_out_item o_out_data,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [31:0]       i_cfg_data
);
    import ort_pkg::*;

    localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_ENTRIES);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_SUB    = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    logic [1:0]    r_state, n_state;
    t_in_item      r_item;
    logic [31:0]   r_timeout;
    logic [31:0]   r_start, n_start;
    logic [31:0]   r_diff;
    logic [CW-1:0] r_total, n_total;
    logic [CW-1:0] r_pending, n_pending;
    logic [CW-1:0] r_success, n_success;
    logic [CW-1:0] r_failure, n_failure;
    logic [CW-1:0] r_rd_idx, n_rd_idx;
    logic [CW-1:0] r_chk_idx, n_chk_idx;
    logic          r_chk_valid, n_chk_valid;
    logic          r_found, n_found;
    logic          r_found_flag, n_found_flag;
    logic [IW-1:0] r_found_idx, n_found_idx;
    logic          r_out_valid, n_out_valid;
    t_out_item     r_out, n_out;

    logic          in_fire;
    logic          out_free;
    logic          rd_en;
    logic          wr_en;
    logic [IW-1:0] wr_addr;
    logic          wr_resolved;
    logic [CW-1:0] pend_dec;
    t_lookup       lookup;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign in_fire  = i_in_valid && o_in_ready;
    assign out_free = !r_out_valid || i_out_ready;
    assign rd_en    = (r_rd_idx < r_total);
    assign pend_dec = r_pending - 1'b1;

    ort_id_store #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_store (
        .i_clk         (i_clk),
        .i_wr_en       (wr_en),
        .i_wr_addr     (wr_addr),
        .i_wr_id       (r_item.request_id),
        .i_wr_resolved (wr_resolved),
        .i_rd_addr     (r_rd_idx[IW-1:0]),
        .i_key         (r_item.request_id),
        .o_lookup      (lookup)
    );

    always_comb begin
        n_state      = r_state;
        n_start      = r_start;
        n_total      = r_total;
        n_pending    = r_pending;
        n_success    = r_success;
        n_failure    = r_failure;
        n_rd_idx     = r_rd_idx;
        n_chk_idx    = r_chk_idx;
        n_chk_valid  = 1'b0;
        n_found      = r_found;
        n_found_flag = r_found_flag;
        n_found_idx  = r_found_idx;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out        = r_out;
        wr_en        = 1'b0;
        wr_addr      = r_total[IW-1:0];
        wr_resolved  = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    n_found  = 1'b0;
                    n_rd_idx = '0;
                    case (i_in_data.operation)
                        OP_START: n_state = ST_FINISH;
                        OP_EXPIRE: n_state = ST_SUB;
                        OP_ADD: begin
                            if (r_total == '0 || i_in_data.request_id == '0
                                || r_total == CNT_MAX) begin
                                n_state = ST_FINISH;
                            end else begin
                                n_state = ST_SCAN;
                            end
                        end
                        default: begin
                            n_state = (r_total == '0) ? ST_FINISH : ST_SCAN;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                // read issued on r_rd_idx, compared in the following cycle
                if (r_chk_valid && lookup.match) begin
                    n_found      = 1'b1;
                    n_found_flag = lookup.resolved;
                    n_found_idx  = r_chk_idx[IW-1:0];
                    n_state      = ST_FINISH;
                end else if (r_chk_valid && CW'(r_chk_idx + 1'b1) == r_total) begin
                    n_state = ST_FINISH;
                end else begin
                    n_chk_valid = rd_en;
                    n_chk_idx   = r_rd_idx;
                    if (rd_en) begin
                        n_rd_idx = r_rd_idx + 1'b1;
                    end
                end
            end
            ST_SUB: begin
                n_state = ST_FINISH;
            end
            default: begin
                if (out_free) begin
                    n_out              = '0;
                    n_out_valid        = 1'b1;
                    n_state            = ST_IDLE;
                    case (r_item.operation)
                        OP_START: begin
                            n_start   = r_item.time_now;
                            n_total   = '0;
                            n_pending = '0;
                            n_success = '0;
                            n_failure = '0;
                        end
                        OP_ADD: begin
                            if (r_item.request_id != '0 && r_total != CNT_MAX
                                && !r_found) begin
                                wr_en              = 1'b1;
                                wr_addr            = r_total[IW-1:0];
                                n_total            = r_total + 1'b1;
                                n_pending          = r_pending + 1'b1;
                                n_out.add_accepted = 1'b1;
                            end
                        end
                        OP_RESOLVE: begin
                            if (!r_found) begin
                                n_out.resolution = RES_UNKNOWN;
                            end else if (r_found_flag || r_pending == '0) begin
                                n_out.resolution = RES_LATE;
                            end else begin
                                wr_en       = 1'b1;
                                wr_addr     = r_found_idx;
                                wr_resolved = 1'b1;
                                n_pending   = pend_dec;
                                if (r_item.success) begin
                                    n_success = r_success + 1'b1;
                                end else begin
                                    n_failure = r_failure + 1'b1;
                                end
                                n_out.resolution = (pend_dec == '0) ? RES_COMPLETED
                                                                    : RES_PENDING;
                            end
                        end
                        default: begin
                            if (r_pending != '0 && r_diff >= r_timeout) begin
                                n_failure     = r_failure + r_pending;
                                n_pending     = '0;
                                n_out.expired = 1'b1;
                            end
                        end
                    endcase
                    n_out.total_count   = 4'(n_total);
                    n_out.pending_count = 4'(n_pending);
                    n_out.success_count = 4'(n_success);
                    n_out.failure_count = 4'(n_failure);
                    if (n_pending != '0) begin
                        n_out.batch_status = BST_PENDING;
                    end else if (n_success == n_total && n_total != '0) begin
                        n_out.batch_status = BST_ALL_OK;
                    end else if (n_success != '0) begin
                        n_out.batch_status = BST_PARTIAL;
                    end else begin
                        n_out.batch_status = BST_ALL_FAIL;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_timeout   <= TIMEOUT_RESET;
            r_start     <= '0;
            r_total     <= '0;
            r_pending   <= '0;
            r_success   <= '0;
            r_failure   <= '0;
            r_chk_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_start     <= n_start;
            r_total     <= n_total;
            r_pending   <= n_pending;
            r_success   <= n_success;
            r_failure   <= n_failure;
            r_chk_valid <= n_chk_valid;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                r_timeout <= i_cfg_data;
            end
        end
    end

    // payload and walk registers
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_item <= i_in_data;
        end
        r_diff       <= r_item.time_now - r_start;
        r_rd_idx     <= n_rd_idx;
        r_chk_idx    <= n_chk_idx;
        r_found      <= n_found;
        r_found_flag <= n_found_flag;
        r_found_idx  <= n_found_idx;
        r_out        <= n_out;
    end

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the outstanding request tracker. A driver feeds
// command transfers from a queue, a predictor tracks the batch alongside the
// core, and a monitor compares every result transfer field by field. The
// timeout register is rewritten between phases while the core is idle.
// ----------------------------------------------------------------------------
module tb_top;
    import ort_pkg::*;

    localparam int ENTRIES = DEF_MAX_ENTRIES;

    logic        clk;
    logic        rst_n      = 1'b0;
    logic        in_valid   = 1'b0;
    logic        in_ready;
    t_in_item    in_data    = '0;
    logic        out_valid;
    logic        out_ready  = 1'b0;
    t_out_item   out_data;
    logic        cfg_valid  = 1'b0;
    logic        cfg_ready;
    logic [31:0] cfg_data   = '0;

    outstanding_request_tracker_core #(
        .MAX_ENTRIES (ENTRIES)
    ) dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // stimulus and checking state
    t_in_item    pending_cmds[$];
    t_out_item   predicted_results[$];
    int unsigned mismatch_cnt = 0;
    int unsigned queued_cnt   = 0;
    bit          calm         = 1'b0;
    int unsigned send_gap     = 0;
    int unsigned recv_stall   = 0;

    // predictor copy of the batch
    logic [31:0] timeout_cfg = TIMEOUT_RESET;
    logic [31:0] ids [ENTRIES];
    bit          done [ENTRIES];
    logic [31:0] t0      = '0;
    int          n_total = 0;
    int          n_pend  = 0;
    int          n_ok    = 0;
    int          n_fail  = 0;

    function automatic t_out_item track_request(input t_in_item it);
        t_out_item   r;
        int          hit;
        logic [31:0] elapsed;
        r       = '0;
        hit     = -1;
        elapsed = it.time_now - t0;
        for (int i = 0; i < n_total; i++) begin
            if (ids[i] == it.request_id) hit = i;
        end
        case (it.operation)
            OP_START: begin
                n_total = 0;
                n_pend  = 0;
                n_ok    = 0;
                n_fail  = 0;
                t0      = it.time_now;
            end
            OP_ADD: begin
                if (it.request_id != 0 && n_total < ENTRIES && hit < 0) begin
                    ids[n_total]  = it.request_id;
                    done[n_total] = 1'b0;
                    n_total++;
                    n_pend++;
                    r.add_accepted = 1'b1;
                end
            end
            OP_RESOLVE: begin
                if (hit >= 0) begin
                    if (done[hit] || n_pend == 0) begin
                        r.resolution = RES_LATE;
                    end else begin
                        done[hit] = 1'b1;
                        n_pend--;
                        if (it.success) n_ok++;
                        else n_fail++;
                        r.resolution = (n_pend == 0) ? RES_COMPLETED : RES_PENDING;
                    end
                end else begin
                    r.resolution = RES_UNKNOWN;
                end
            end
            OP_EXPIRE: begin
                if (n_pend > 0 && elapsed >= timeout_cfg) begin
                    n_fail += n_pend;
                    n_pend = 0;
                    r.expired = 1'b1;
                end
            end
        endcase
        r.total_count   = 4'(n_total);
        r.pending_count = 4'(n_pend);
        r.success_count = 4'(n_ok);
        r.failure_count = 4'(n_fail);
        if (n_pend > 0)                     r.batch_status = BST_PENDING;
        else if (n_ok == n_total && n_total > 0) r.batch_status = BST_ALL_OK;
        else if (n_ok > 0)                  r.batch_status = BST_PARTIAL;
        else                                r.batch_status = BST_ALL_FAIL;
        return r;
    endfunction

    // driver: back-to-back transfers keep valid high with a single update
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            send_gap = 0;
        end else if (!in_valid || in_ready) begin
            if (in_valid) begin
                predicted_results.push_back(track_request(in_data));
                send_gap = calm ? 0 : $urandom_range(0, 19);
            end
            if (send_gap == 0 && pending_cmds.size() != 0) begin
                in_data  <= pending_cmds.pop_front();
                in_valid <= 1'b1;
            end else begin
                in_valid <= 1'b0;
                if (send_gap != 0) send_gap--;
            end
        end
    end

    task automatic report_field(input string name, input int unsigned want,
                                input int unsigned got);
        if (want != got) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
                $display("mismatch on %s: expected %0d, got %0d", name, want, got);
        end
    endtask

    task automatic check_result(input t_out_item got);
        t_out_item want;
        if (predicted_results.size() == 0) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
                $display("result transfer with nothing outstanding: %p", got);
        end else begin
            want = predicted_results.pop_front();
            report_field("add_accepted",  32'(want.add_accepted),  32'(got.add_accepted));
            report_field("resolution",    32'(want.resolution),    32'(got.resolution));
            report_field("expired",       32'(want.expired),       32'(got.expired));
            report_field("total_count",   32'(want.total_count),   32'(got.total_count));
            report_field("pending_count", 32'(want.pending_count), 32'(got.pending_count));
            report_field("success_count", 32'(want.success_count), 32'(got.success_count));
            report_field("failure_count", 32'(want.failure_count), 32'(got.failure_count));
            report_field("batch_status",  32'(want.batch_status),  32'(got.batch_status));
        end
    endtask

    // monitor: stall drawn after every result transfer
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
            recv_stall = 0;
        end else begin
            if (out_valid && out_ready) begin
                check_result(out_data);
                recv_stall = calm ? 0 : $urandom_range(0, 19);
            end
            if (recv_stall != 0) begin
                out_ready <= 1'b0;
                recv_stall--;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    function automatic void queue_cmd(input logic [1:0] op, input logic [31:0] id,
                                      input logic ok, input logic [31:0] now);
        t_in_item it;
        it.operation  = op;
        it.request_id = id;
        it.success    = ok;
        it.time_now   = now;
        pending_cmds.push_back(it);
        queued_cnt++;
    endfunction

    task automatic wait_drained();
        while (pending_cmds.size() != 0 || in_valid || predicted_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_timeout(input logic [31:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid   <= 1'b0;
        timeout_cfg = value;
    endtask

    // one batch: a start, then mostly adds and resolves drawn from a small
    // identifier pool, expiry checks near the timeout, and some noise
    task automatic gen_batch(input int n_ops);
        logic [31:0] pool [10];
        logic [31:0] start_t;
        logic [31:0] delta;
        int          npool;
        int          r;
        npool   = $urandom_range(1, 10);
        start_t = $urandom;
        for (int k = 0; k < npool; k++)
            pool[k] = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 20) : $urandom;
        queue_cmd(OP_START, $urandom, 1'($urandom_range(0, 1)), start_t);
        for (int k = 0; k < n_ops; k++) begin
            r = $urandom_range(0, 99);
            if (r < 35) begin
                queue_cmd(OP_ADD,
                          ($urandom_range(0, 19) == 0) ? 32'd0
                          : ($urandom_range(0, 9) == 0) ? $urandom
                          : pool[$urandom_range(0, npool - 1)],
                          1'($urandom_range(0, 1)), $urandom);
            end else if (r < 75) begin
                queue_cmd(OP_RESOLVE,
                          ($urandom_range(0, 19) == 0) ? 32'd0
                          : ($urandom_range(0, 9) == 0) ? $urandom
                          : pool[$urandom_range(0, npool - 1)],
                          1'($urandom_range(0, 1)), $urandom);
            end else if (r < 88) begin
                delta = 32'($urandom_range(0, 6)) - 32'd3;
                queue_cmd(OP_EXPIRE, $urandom, 1'($urandom_range(0, 1)),
                          ($urandom_range(0, 9) < 3) ? $urandom
                          : start_t + timeout_cfg + delta);
            end else begin
                queue_cmd(2'($urandom_range(0, 3)), $urandom, 1'($urandom_range(0, 1)),
                          $urandom);
            end
        end
    endtask

    task automatic random_phase(input int unsigned n_items);
        int unsigned target;
        target = queued_cnt + n_items;
        while (queued_cnt < target) begin
            calm = ($urandom_range(0, 3) == 0);
            gen_batch($urandom_range(4, 24));
            // let each batch go out before mixing the idling mode
            wait_drained();
        end
        calm = 1'b0;
    endtask

    initial begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // directed, default timeout
        queue_cmd(OP_RESOLVE, 32'd5, 1'b1, 32'd0);      // empty batch
        queue_cmd(OP_EXPIRE, 32'd0, 1'b0, 32'h1234_5678); // nothing pending
        queue_cmd(OP_START, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_F000);
        queue_cmd(OP_ADD, 32'd0, 1'b0, 32'd0);          // zero id refused
        queue_cmd(OP_ADD, 32'hFFFF_FFFF, 1'b0, 32'd0);
        queue_cmd(OP_ADD, 32'd1, 1'b0, 32'd0);
        queue_cmd(OP_ADD, 32'd1, 1'b0, 32'd0);          // duplicate
        queue_cmd(OP_RESOLVE, 32'd0, 1'b1, 32'd0);
        queue_cmd(OP_RESOLVE, 32'd1, 1'b1, 32'd0);
        queue_cmd(OP_RESOLVE, 32'd1, 1'b0, 32'd0);      // already settled
        for (int k = 2; k <= 8; k++)
            queue_cmd(OP_ADD, 32'(k), 1'b0, 32'd0);     // last one hits a full table
        queue_cmd(OP_RESOLVE, 32'd2, 1'b0, 32'd0);
        queue_cmd(OP_EXPIRE, 32'd0, 1'b0, 32'h0000_0387); // one tick short, wrapped
        queue_cmd(OP_EXPIRE, 32'd0, 1'b1, 32'h0000_0388);
        queue_cmd(OP_RESOLVE, 32'd3, 1'b1, 32'd0);      // nothing pending
        queue_cmd(OP_START, 32'd0, 1'b0, 32'h8000_0000);
        queue_cmd(OP_ADD, 32'd11, 1'b1, 32'd0);
        queue_cmd(OP_EXPIRE, 32'd0, 1'b0, 32'h8000_1388); // all failed
        queue_cmd(OP_ADD, 32'd12, 1'b1, 32'd0);
        queue_cmd(OP_RESOLVE, 32'd11, 1'b1, 32'd0);     // expired entry settles
        wait_drained();

        write_timeout(32'd0);
        queue_cmd(OP_START, 32'd0, 1'b0, 32'd7);
        queue_cmd(OP_ADD, 32'hA5A5_A5A5, 1'b0, 32'd0);
        queue_cmd(OP_RESOLVE, 32'hA5A5_A5A5, 1'b1, 32'd0); // all succeeded
        queue_cmd(OP_ADD, 32'h5A5A_5A5A, 1'b0, 32'd0);
        queue_cmd(OP_EXPIRE, 32'd0, 1'b0, 32'd7);       // zero timeout fires at once
        wait_drained();
        random_phase(330);

        write_timeout(32'hFFFF_FFFF);
        queue_cmd(OP_START, 32'd0, 1'b0, 32'd0);
        queue_cmd(OP_ADD, 32'd1, 1'b0, 32'd0);
        queue_cmd(OP_EXPIRE, 32'd0, 1'b0, 32'hFFFF_FFFE);
        queue_cmd(OP_EXPIRE, 32'd0, 1'b0, 32'hFFFF_FFFF);
        wait_drained();
        random_phase(330);

        write_timeout(32'd1);
        random_phase(330);
        write_timeout($urandom);
        random_phase(330);
        write_timeout($urandom_range(0, 64));
        random_phase(330);
        write_timeout(TIMEOUT_RESET);
        random_phase(330);

        wait_drained();
        repeat (20) @(posedge clk);
        if (mismatch_cnt == 0 && predicted_results.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
